### rtl/core/sdsc_pkg.sv
// shared types, constants and the half-order table for the strict der check
`timescale 1ns / 1ps
`default_nettype none

package sdsc_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned NUM_WORDS = 8;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned POS_W     = 7;
	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);

	localparam logic [POS_W-1:0] MAX_TOTAL = 7'd73;
	localparam logic [POS_W-1:0] MIN_POS   = 7'd8;
	localparam logic [POS_W-1:0] MAX_POS   = 7'd72;
	localparam logic [7:0] TAG_SEQ   = 8'h30;
	localparam logic [7:0] TAG_INT   = 8'h02;
	localparam logic [7:0] HASH_ALL  = 8'h01;
	localparam logic [7:0] MAX_ILEN  = 8'd33;
	localparam logic [7:0] FULL_ILEN = 8'd32;
	localparam logic [IDX_W-1:0] WORD_LAST = 3'd7;

	localparam logic [1:0] CMP_EQ      = 2'd0;
	localparam logic [1:0] CMP_LESS    = 2'd1;
	localparam logic [1:0] CMP_GREATER = 2'd2;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic                  ok;
		word_t [NUM_WORDS-1:0] words;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic len_ok(input logic [7:0] len);
		return (len != 8'd0) && (len <= MAX_ILEN);
	endfunction

	// byte idx of half the group order, most significant byte first
	function automatic logic [7:0] half_order(input logic [4:0] idx);
		logic [7:0] v;
		case (idx) inside
			5'd0:          v = 8'h7F;
			[5'd1:5'd15]:  v = 8'hFF;
			5'd16:         v = 8'h5D;
			5'd17:         v = 8'h57;
			5'd18:         v = 8'h6E;
			5'd19:         v = 8'h73;
			5'd20:         v = 8'h57;
			5'd21:         v = 8'hA4;
			5'd22:         v = 8'h50;
			5'd23:         v = 8'h1D;
			5'd24:         v = 8'hDF;
			5'd25:         v = 8'hE9;
			5'd26:         v = 8'h2F;
			5'd27:         v = 8'h46;
			5'd28:         v = 8'h68;
			5'd29:         v = 8'h1B;
			5'd30:         v = 8'h20;
			5'd31:         v = 8'hA0;
			default:       v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sdsc_front.sv
// byte parser: strict der rules, low-s compare, r and s shift registers
`timescale 1ns / 1ps
`default_nettype none

module sdsc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      sig_byte,
	input  wire logic            last_byte,
	output sdsc_pkg::frame_t     frame,
	output logic                 push
);

	logic [sdsc_pkg::POS_W-1:0] pos_q, pos_n;
	logic [7:0]   decl_q, decl_n;
	logic [7:0]   rlen_q, rlen_n;
	logic [7:0]   slen_q, slen_n;
	logic [7:0]   lead_q, lead_n;
	logic         err_q, err_n;
	logic [1:0]   cmp_q, cmp_n;
	logic [255:0] r_q, r_n;
	logic [255:0] s_q, s_n;
	logic         ok;

	logic [8:0] k9, rlen9, slen9, j9, jx9;
	logic [4:0] hidx;
	logic [7:0] hbyte;

	assign k9    = {2'b00, pos_q} - 9'd4;
	assign rlen9 = {1'b0, rlen_q};
	assign slen9 = {1'b0, slen_q};
	assign j9    = k9 - rlen9 - 9'd2;
	assign jx9   = j9 + 9'd32;
	assign hidx  = 5'(jx9 - slen9);
	assign hbyte = sdsc_pkg::half_order(hidx);

	always_comb begin
		pos_n  = pos_q;
		decl_n = decl_q;
		rlen_n = rlen_q;
		slen_n = slen_q;
		lead_n = lead_q;
		err_n  = err_q;
		cmp_n  = cmp_q;
		r_n    = r_q;
		s_n    = s_q;
		ok     = 1'b0;
		if (accept) begin
			err_n = err_q | (pos_q >= sdsc_pkg::MAX_TOTAL);
			if (!last_byte) begin
				if (pos_q < sdsc_pkg::MAX_TOTAL) begin
					pos_n = pos_q + 7'd1;
					if (pos_q == 7'd0) begin
						if (sig_byte != sdsc_pkg::TAG_SEQ) err_n = 1'b1;
					end else if (pos_q == 7'd1) begin
						decl_n = sig_byte;
					end else if (pos_q == 7'd2) begin
						if (sig_byte != sdsc_pkg::TAG_INT) err_n = 1'b1;
					end else if (pos_q == 7'd3) begin
						rlen_n = sig_byte;
						if (!sdsc_pkg::len_ok(sig_byte)) err_n = 1'b1;
					end else if (sdsc_pkg::len_ok(rlen_q)) begin
						if (k9 < rlen9) begin
							if (k9 == 9'd0) begin
								lead_n = sig_byte;
								if (sig_byte[7]) err_n = 1'b1;
							end else if (k9 == 9'd1 && rlen_q > 8'd1 && lead_q == 8'd0
									&& !sig_byte[7]) begin
								err_n = 1'b1;
							end
							r_n = {r_q[247:0], sig_byte};
						end else if (k9 == rlen9) begin
							if (sig_byte != sdsc_pkg::TAG_INT) err_n = 1'b1;
						end else if (k9 == rlen9 + 9'd1) begin
							slen_n = sig_byte;
							if (!sdsc_pkg::len_ok(sig_byte)) err_n = 1'b1;
							cmp_n = (sig_byte < sdsc_pkg::FULL_ILEN) ? sdsc_pkg::CMP_LESS
								: sdsc_pkg::CMP_EQ;
						end else if (!sdsc_pkg::len_ok(slen_q) || j9 >= slen9) begin
							err_n = 1'b1;
						end else begin
							if (j9 == 9'd0) begin
								lead_n = sig_byte;
								if (sig_byte[7]) err_n = 1'b1;
							end else if (j9 == 9'd1 && slen_q > 8'd1 && lead_q == 8'd0
									&& !sig_byte[7]) begin
								err_n = 1'b1;
							end
							s_n = {s_q[247:0], sig_byte};
							if (jx9 >= slen9 && cmp_q == sdsc_pkg::CMP_EQ) begin
								if (sig_byte < hbyte) cmp_n = sdsc_pkg::CMP_LESS;
								else if (sig_byte > hbyte) cmp_n = sdsc_pkg::CMP_GREATER;
							end
						end
					end
				end
			end else begin
				ok = !err_n
					&& sig_byte == sdsc_pkg::HASH_ALL
					&& pos_q >= sdsc_pkg::MIN_POS && pos_q <= sdsc_pkg::MAX_POS
					&& ({1'b0, decl_q} + 9'd2) == {2'b00, pos_q}
					&& sdsc_pkg::len_ok(rlen_q) && sdsc_pkg::len_ok(slen_q)
					&& (10'd6 + {2'b00, rlen_q} + {2'b00, slen_q}) == {3'b000, pos_q}
					&& cmp_q != sdsc_pkg::CMP_GREATER;
				pos_n  = '0;
				decl_n = '0;
				rlen_n = '0;
				slen_n = '0;
				lead_n = '0;
				err_n  = 1'b0;
				cmp_n  = sdsc_pkg::CMP_EQ;
				r_n    = '0;
				s_n    = '0;
			end
		end
	end

	always_comb begin
		frame.ok = ok;
		for (int i = 0; i < 4; i++) begin
			frame.words[i]     = ok ? r_q[255 - 64*i -: 64] : '0;
			frame.words[i + 4] = ok ? s_q[255 - 64*i -: 64] : '0;
		end
	end

	assign push = accept & last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			decl_q <= '0;
			rlen_q <= '0;
			slen_q <= '0;
			lead_q <= '0;
			err_q  <= 1'b0;
			cmp_q  <= sdsc_pkg::CMP_EQ;
			r_q    <= '0;
			s_q    <= '0;
		end else begin
			pos_q  <= pos_n;
			decl_q <= decl_n;
			rlen_q <= rlen_n;
			slen_q <= slen_n;
			lead_q <= lead_n;
			err_q  <= err_n;
			cmp_q  <= cmp_n;
			r_q    <= r_n;
			s_q    <= s_n;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sdsc_queue.sv
// short frame queue between parser and word emitter
`timescale 1ns / 1ps
`default_nettype none

module sdsc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sdsc_pkg::frame_t  wr_frame,
	input  wire logic              pop,
	output sdsc_pkg::frame_t       head,
	output sdsc_pkg::qstat_t       stat
);

	sdsc_pkg::frame_t entry_q [sdsc_pkg::QDEPTH];
	logic [sdsc_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [sdsc_pkg::QPTR_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (sdsc_pkg::QPTR_W+1)'(sdsc_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= wr_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/sdsc_back.sv
// word emitter: walks the eight words of the head frame
`timescale 1ns / 1ps
`default_nettype none

module sdsc_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sdsc_pkg::frame_t            head,
	input  wire sdsc_pkg::qstat_t            stat,
	output logic                             pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [sdsc_pkg::WORD_W-1:0]      m_tdata,
	output logic [sdsc_pkg::IDX_W:0]         m_tuser,
	output logic                             m_tlast
);

	logic [sdsc_pkg::IDX_W-1:0] idx_q;
	logic                       take;

	assign m_tvalid = !stat.empty;
	assign m_tdata  = head.words[idx_q];
	assign m_tuser  = {head.ok, idx_q};
	assign m_tlast  = (idx_q == sdsc_pkg::WORD_LAST);
	assign take     = m_tvalid & m_tready;
	assign pop      = take & m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/strict_der_signature_check.sv
// top level of the strict der signature check with low-s rule
//
//  channel | dir | tdata            | tuser                       | tlast
//  s_*     | in  | [7:0] sig_byte   | -                           | last_byte
//  m_*     | out | [63:0] word_value| [2:0] word_index, [3] valid | last_word
//
// one byte per cycle enters the parser while the queue is not full, checks finish as the byte arrives
// the last byte queues a frame of eight words; words leave one per cycle while m_tready is high
// a queue of two frames sits between parser and emitter; input stalls only when full
// reset clears parser state and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module strict_der_signature_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] sig_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [63:0] word_value
	output logic [3:0]       m_tuser,   // [2:0] word_index, [3] sig_valid
	output logic             m_tlast
);

	sdsc_pkg::frame_t new_frame, head;
	sdsc_pkg::qstat_t stat;
	logic             accept, push, pop;

	assign s_tready = !stat.full;
	assign accept   = s_tvalid & s_tready;

	sdsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sig_byte  (s_tdata),
		.last_byte (s_tlast),
		.frame     (new_frame),
		.push      (push)
	);

	sdsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (new_frame),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	sdsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.stat     (stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### dv/strict_der_signature_check_test.sv
// self-checking testbench for the strict der signature check: predicts the eight words per request run
`timescale 1ns / 1ps

module strict_der_signature_check_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_BUDGET = 330;
	localparam int DIRECTED_COUNT = 12;
	localparam logic [255:0] HALF_N =
		256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_5D576E73_57A4501D_DFE92F46_681B20A0;

	typedef struct {
		logic [sdsc_pkg::IDX_W-1:0] idx;
		sdsc_pkg::word_t            value;
		logic                       ok;
		logic                       tail;
	} word_exp_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_BYTE,
		FLAW_HASH,
		FLAW_SEQ_LEN,
		FLAW_TRUNC,
		FLAW_EXTRA,
		FLAW_ILEN,
		FLAW_LONG,
		FLAW_NOISE
	} flaw_e;

	class sig_scoreboard;
		logic [sdsc_pkg::POS_W-1:0] pos;
		logic [7:0]       seq_len;
		logic [7:0]       r_len;
		logic [7:0]       s_len;
		logic [7:0]       lead;
		logic             bad;
		logic [1:0]       s_cmp;
		logic [255:0]     r_val;
		logic [255:0]     s_val;
		word_exp_t        pending_words[$];
		int               errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			pos = '0;
			seq_len = '0;
			r_len = '0;
			s_len = '0;
			lead = '0;
			bad = 1'b0;
			s_cmp = sdsc_pkg::CMP_EQ;
			r_val = '0;
			s_val = '0;
		endfunction

		function bit ilen_fits(logic [7:0] len);
			return len inside {[8'd1:sdsc_pkg::MAX_ILEN]};
		endfunction

		// sign and needless-zero rules on integer content byte k
		function void integer_rules(int k, int len, logic [7:0] b);
			if (k == 0) begin
				lead = b;
				if (b[7]) bad = 1'b1;
			end else if (k == 1 && len > 1 && lead == 8'h00 && !b[7]) begin
				bad = 1'b1;
			end
		endfunction

		function void parse_body(int p, logic [7:0] b);
			int k;
			int j;
			int ix;
			logic [7:0] hb;
			if (p == 0) begin
				if (b != sdsc_pkg::TAG_SEQ) bad = 1'b1;
				return;
			end
			if (p == 1) begin
				seq_len = b;
				return;
			end
			if (p == 2) begin
				if (b != sdsc_pkg::TAG_INT) bad = 1'b1;
				return;
			end
			if (p == 3) begin
				r_len = b;
				if (!ilen_fits(b)) bad = 1'b1;
				return;
			end
			if (!ilen_fits(r_len)) return;
			k = p - 4;
			if (k < int'(r_len)) begin
				integer_rules(k, int'(r_len), b);
				r_val = {r_val[247:0], b};
			end else if (k == int'(r_len)) begin
				if (b != sdsc_pkg::TAG_INT) bad = 1'b1;
			end else if (k == int'(r_len) + 1) begin
				s_len = b;
				if (!ilen_fits(b)) bad = 1'b1;
				s_cmp = (b < sdsc_pkg::FULL_ILEN) ? sdsc_pkg::CMP_LESS : sdsc_pkg::CMP_EQ;
			end else begin
				j = k - int'(r_len) - 2;
				if (!ilen_fits(s_len) || j >= int'(s_len)) begin
					bad = 1'b1;
					return;
				end
				integer_rules(j, int'(s_len), b);
				s_val = {s_val[247:0], b};
				if (j + 32 >= int'(s_len) && s_cmp == sdsc_pkg::CMP_EQ) begin
					ix = (j + 32 - int'(s_len)) % 32;
					hb = HALF_N[255 - 8*ix -: 8];
					if (b < hb) s_cmp = sdsc_pkg::CMP_LESS;
					else if (b > hb) s_cmp = sdsc_pkg::CMP_GREATER;
				end
			end
		endfunction

		function void absorb_byte(logic [7:0] b, logic tail);
			int total;
			bit ok;
			word_exp_t e;
			if (pos >= sdsc_pkg::MAX_TOTAL) bad = 1'b1;
			if (!tail) begin
				if (pos < sdsc_pkg::MAX_TOTAL) begin
					parse_body(int'(pos), b);
					pos = pos + 1'b1;
				end
				return;
			end
			total = int'(pos) + 1;
			ok = !bad && b == sdsc_pkg::HASH_ALL && total >= 9
				&& total <= int'(sdsc_pkg::MAX_TOTAL)
				&& int'(seq_len) + 2 == int'(pos)
				&& ilen_fits(r_len) && ilen_fits(s_len)
				&& 6 + int'(r_len) + int'(s_len) == int'(pos)
				&& s_cmp != sdsc_pkg::CMP_GREATER;
			for (int i = 0; i < sdsc_pkg::NUM_WORDS; i++) begin
				e.idx = i[sdsc_pkg::IDX_W-1:0];
				if (!ok) e.value = '0;
				else if (i < 4) e.value = r_val[255 - 64*i -: 64];
				else e.value = s_val[255 - 64*(i-4) -: 64];
				e.ok = ok;
				e.tail = (e.idx == sdsc_pkg::WORD_LAST);
				pending_words.push_back(e);
			end
			clear();
		endfunction

		function void check_word(logic [sdsc_pkg::IDX_W-1:0] idx, sdsc_pkg::word_t value,
				logic ok, logic tail);
			word_exp_t e;
			if (pending_words.size() == 0) begin
				$error("unexpected word: index %0d value %h", idx, value);
				errors++;
				return;
			end
			e = pending_words.pop_front();
			if (idx !== e.idx) begin
				$error("word_index: expected %0d, got %0d", e.idx, idx);
				errors++;
			end
			if (value !== e.value) begin
				$error("word_value: expected %h, got %h", e.value, value);
				errors++;
			end
			if (ok !== e.ok) begin
				$error("sig_valid: expected %0b, got %0b", e.ok, ok);
				errors++;
			end
			if (tail !== e.tail) begin
				$error("last_word: expected %0b, got %0b", e.tail, tail);
				errors++;
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	sig_scoreboard sb;
	logic [7:0]    sig_bytes[$];
	int            words_seen = 0;
	int            cycles = 0;
	int            burst_left = 0;
	bit            gaps_on = 1'b1;

	strict_der_signature_check DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// both sides are stable at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.absorb_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				sb.check_word(m_tuser[2:0], m_tdata, m_tuser[3], m_tlast);
				words_seen <= words_seen + 1;
			end
		end
	end

	// receiver: stall pattern in segments, plus one long hold-off
	initial begin
		int seg_left;
		int mode;
		int hold_left;
		bit held;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_seen >= 24) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(10, 80);
				end
				seg_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic idle(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic tail);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= tail;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		idle(1);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic send_signature();
		int n;
		n = sig_bytes.size();
		gaps_on = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n; i++) begin
			if (gaps_on && burst_left <= 0) begin
				idle($urandom_range(1, 8));
				burst_left = $urandom_range(1, 24);
			end
			push_byte(sig_bytes[i], i == n - 1);
			burst_left--;
		end
	endtask

	task automatic add_integer(input int len);
		if (len == 1) begin
			sig_bytes.push_back(8'($urandom_range(0, 127)));
		end else if (len == 33 || $urandom_range(0, 4) == 0) begin
			sig_bytes.push_back(8'h00);
			sig_bytes.push_back(8'($urandom_range(128, 255)));
			repeat (len - 2) sig_bytes.push_back(8'($urandom));
		end else begin
			sig_bytes.push_back(8'($urandom_range(1, 127)));
			repeat (len - 1) sig_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic build_signature(input int rl, input int sl);
		sig_bytes.delete();
		sig_bytes.push_back(sdsc_pkg::TAG_SEQ);
		sig_bytes.push_back(8'(4 + rl + sl));
		sig_bytes.push_back(sdsc_pkg::TAG_INT);
		sig_bytes.push_back(8'(rl));
		add_integer(rl);
		sig_bytes.push_back(sdsc_pkg::TAG_INT);
		sig_bytes.push_back(8'(sl));
		add_integer(sl);
		sig_bytes.push_back(sdsc_pkg::HASH_ALL);
	endtask

	// overwrite a 32-byte s with a given value
	task automatic set_s_value(input logic [255:0] v);
		int rl;
		rl = sig_bytes[3];
		for (int i = 0; i < 32; i++) sig_bytes[6 + rl + i] = v[255 - 8*i -: 8];
	endtask

	task automatic apply_flaw(input flaw_e f);
		int n;
		int at;
		int rl;
		int target;
		logic [7:0] v;
		n = sig_bytes.size();
		rl = sig_bytes[3];
		case (f)
			FLAW_BYTE: begin
				at = $urandom_range(0, n - 2);
				sig_bytes[at] = sig_bytes[at] ^ 8'(1 << $urandom_range(0, 7));
			end
			FLAW_HASH: begin
				do v = 8'($urandom); while (v == sdsc_pkg::HASH_ALL);
				sig_bytes[n - 1] = v;
			end
			FLAW_SEQ_LEN: sig_bytes[1] = sig_bytes[1] + 8'($urandom_range(1, 255));
			FLAW_TRUNC: repeat ($urandom_range(1, n - 2)) sig_bytes.delete(sig_bytes.size() - 2);
			FLAW_EXTRA: begin
				repeat ($urandom_range(1, 3))
					sig_bytes.insert(sig_bytes.size() - 1, 8'($urandom));
			end
			FLAW_ILEN: begin
				at = $urandom_range(0, 1) ? 3 : 5 + rl;
				case ($urandom_range(0, 2))
					0: v = 8'd0;
					1: v = 8'd34;
					default: v = 8'($urandom);
				endcase
				sig_bytes[at] = v;
			end
			FLAW_LONG: begin
				target = $urandom_range(74, 78);
				while (sig_bytes.size() < target)
					sig_bytes.insert(sig_bytes.size() - 1, 8'($urandom));
			end
			FLAW_NOISE: begin
				sig_bytes.delete();
				repeat ($urandom_range(1, 12)) sig_bytes.push_back(8'($urandom));
			end
			default: ;
		endcase
	endtask

	task automatic directed_signature(input int d);
		case (d)
			0: begin
				build_signature(1, 1);
				sig_bytes[4] = 8'h00;
				sig_bytes[7] = 8'h7F;
			end
			1: begin
				build_signature(33, 32);
				set_s_value(HALF_N);
			end
			2: build_signature(1, 33);
			3: begin
				build_signature(1, 32);
				set_s_value(HALF_N + 256'd1);
			end
			4: begin
				sig_bytes.delete();
				sig_bytes.push_back(sdsc_pkg::HASH_ALL);
			end
			5: begin
				build_signature(1, 1);
				sig_bytes.delete(7);
			end
			6: begin
				build_signature(3, 3);
				sig_bytes[sig_bytes.size() - 1] = 8'h81;
			end
			7: begin
				build_signature(2, 2);
				sig_bytes[4] = sig_bytes[4] | 8'h80;
			end
			8: begin
				build_signature(2, 2);
				sig_bytes[4] = 8'h00;
				sig_bytes[5] = 8'h12;
			end
			9: begin
				build_signature(1, 1);
				apply_flaw(FLAW_LONG);
			end
			10: begin
				build_signature(3, 3);
				sig_bytes[9] = sig_bytes[9] | 8'h80;
			end
			default: begin
				build_signature(2, 2);
				sig_bytes[8] = 8'h00;
				sig_bytes[9] = 8'h05;
			end
		endcase
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return $urandom_range(1, 6);
		if (r == 7) return 32;
		return $urandom_range(1, 33);
	endfunction

	task automatic random_signature();
		flaw_e f;
		build_signature(pick_length(), pick_length());
		if ($urandom_range(0, 9) < 6) f = FLAW_NONE;
		else f = flaw_e'($urandom_range(int'(FLAW_BYTE), int'(FLAW_NOISE)));
		apply_flaw(f);
	endtask

	initial begin
		int sent_bytes;
		sent_bytes = 0;
		wait (arst_n);
		@(posedge clk);
		for (int d = 0; d < DIRECTED_COUNT; d++) begin
			directed_signature(d);
			sent_bytes += sig_bytes.size();
			send_signature();
		end
		wait_drained();
		while (sent_bytes < ITEM_BUDGET) begin
			random_signature();
			sent_bytes += sig_bytes.size();
			send_signature();
			if ($urandom_range(0, 7) == 0) wait_drained();
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
